// File: hdl/ncwg_pkg.sv
// Shared widths, register indexes and status types of the shortlex word generator.
package ncwg_pkg;

	localparam int MAX_LEN_DEF     = 32;
	localparam int MAX_SYMBOLS_DEF = 56;

	localparam int N_W          = 31;  // word index
	localparam int K_W          = 6;   // symbol count and base-k digit
	localparam int SYM_W        = 8;   // one character
	localparam int POS_W        = 5;   // character position
	localparam int CFG_W        = 64;  // widest configuration register
	localparam int CFG_IDX_W    = 3;
	localparam int NUM_SYM_REGS = 7;
	localparam int SYM_PER_REG  = CFG_W / SYM_W;
	// k^L stays below 2^37 and the running sum below 2^38 while the search runs
	localparam int CNT_W        = 38;

	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_BASE = CFG_IDX_W'(1);

	typedef struct packed {
		logic           done;
		logic           too_long;
		logic [N_W-1:0] rem;
	} search_res_t;

	typedef struct packed {
		logic           done;
		logic [K_W-1:0] digit;
		logic [N_W-1:0] quot;
	} div_res_t;

endpackage

// File: hdl/ncwg_len_search.sv
// Word length search: running sum of k^L with a bit-serial multiplier.
module ncwg_len_search #(
	parameter int MAX_LEN = ncwg_pkg::MAX_LEN_DEF,
	localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ncwg_pkg::N_W-1:0]  n,
	input  logic [ncwg_pkg::K_W-1:0]  k,
	output ncwg_pkg::search_res_t     res,
	output logic [LEN_W-1:0]          len
);

	localparam int CNT_W = ncwg_pkg::CNT_W;
	localparam int K_W   = ncwg_pkg::K_W;
	localparam int BIT_W = $clog2(K_W);

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MUL, S_ADD, S_DONE} state_t;

	state_t                   state_q;
	logic [ncwg_pkg::N_W-1:0] n_q;
	logic [K_W-1:0]           k_q;
	logic [K_W-1:0]           mplier_q;
	logic [CNT_W-1:0]         pw_q;
	logic [CNT_W-1:0]         counted_q;
	logic [CNT_W-1:0]         before_q;
	logic [CNT_W-1:0]         prod_q;
	logic [CNT_W-1:0]         mcand_q;
	logic [BIT_W-1:0]         bit_q;
	logic [LEN_W-1:0]         len_q;
	logic                     reached;
	logic                     stop;

	assign reached = counted_q >= CNT_W'(n_q);
	assign stop    = reached || (len_q == LEN_W'(MAX_LEN));

	assign res.done     = (state_q == S_DONE);
	assign res.too_long = !reached;
	assign res.rem      = ncwg_pkg::N_W'(CNT_W'(n_q) - before_q - CNT_W'(1));
	assign len          = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			k_q       <= '0;
			mplier_q  <= '0;
			pw_q      <= '0;
			counted_q <= '0;
			before_q  <= '0;
			prod_q    <= '0;
			mcand_q   <= '0;
			bit_q     <= '0;
			len_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q       <= n;
						k_q       <= k;
						pw_q      <= CNT_W'(1);
						counted_q <= '0;
						before_q  <= '0;
						len_q     <= '0;
						state_q   <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stop) begin
						state_q <= S_DONE;
					end else begin
						mcand_q  <= pw_q;
						mplier_q <= k_q;
						prod_q   <= '0;
						bit_q    <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					// one bit of k per cycle
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					bit_q    <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(K_W - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					before_q  <= counted_q;
					counted_q <= counted_q + prod_q;
					pw_q      <= prod_q;
					len_q     <= len_q + LEN_W'(1);
					state_q   <= S_CHECK;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/ncwg_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, remainder is one base-k digit.
module ncwg_serial_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ncwg_pkg::N_W-1:0]  dividend,
	input  logic [ncwg_pkg::K_W-1:0]  divisor,
	output ncwg_pkg::div_res_t        res
);

	localparam int N_W   = ncwg_pkg::N_W;
	localparam int K_W   = ncwg_pkg::K_W;
	localparam int CNT_W = $clog2(N_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   dvd_q;
	logic [K_W-1:0]   rem_q;
	logic [K_W-1:0]   dsr_q;
	logic [K_W:0]     trial;
	logic [K_W:0]     diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	assign res.done  = done_q;
	assign res.digit = rem_q;
	assign res.quot  = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				// shift the quotient bit in where the dividend bit leaves
				rem_q <= fits ? diff[K_W-1:0] : trial[K_W-1:0];
				dvd_q <= {dvd_q[N_W-2:0], fits};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/nth_candidate_word_generator.sv
// Top level of the shortlex word generator: configuration, sequencing, digit stack and output.
//
// Give a one-based word_index n and the block returns the n-th word in shortlex order over
// the configured alphabet of k = symbol_count symbols, one character per output item, most
// significant first, with char_position counting from zero and last_char on the final one.
// An index of zero is the empty word: the item is taken and nothing comes out. When the word
// would be longer than MAX_LEN characters, a single item comes out with too_long, last_char,
// a zero symbol and position zero. A symbol count of zero acts as one; a count above
// MAX_SYMBOLS acts as MAX_SYMBOLS. The block works on one index at a time and takes the next
// index as soon as the last character of the previous word sits in the output register.
// For a word of length L the length search runs a serial multiplier over the bits of the
// symbol count, plus one add and one compare per length step; the bit-serial divider then
// peels off one base-k digit per 31-bit division, and the emit state hands out the
// characters, holding while the output item is not taken. Write configuration only while
// no index is in flight.
module nth_candidate_word_generator #(
	parameter int MAX_LEN     = ncwg_pkg::MAX_LEN_DEF,
	parameter int MAX_SYMBOLS = ncwg_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ncwg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ncwg_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ncwg_pkg::N_W-1:0]        word_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ncwg_pkg::SYM_W-1:0]      out_symbol,
	output logic [ncwg_pkg::POS_W-1:0]      char_position,
	output logic                            last_char,
	output logic                            too_long
);

	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int K_W       = ncwg_pkg::K_W;
	localparam int N_W       = ncwg_pkg::N_W;
	localparam int SYM_W     = ncwg_pkg::SYM_W;
	localparam int CFG_W     = ncwg_pkg::CFG_W;
	localparam int REG_SEL_W = K_W - $clog2(ncwg_pkg::SYM_PER_REG);
	localparam int BYTE_W    = $clog2(ncwg_pkg::SYM_PER_REG);
	localparam logic [K_W-1:0] K_SAT = K_W'(MAX_SYMBOLS);

	typedef enum logic [2:0] {T_IDLE, T_SEARCH, T_DIV, T_FLAG, T_EMIT} state_t;

	// configuration registers
	logic [K_W-1:0]   k_q;
	logic [CFG_W-1:0] sym_q [ncwg_pkg::NUM_SYM_REGS];
	logic [K_W-1:0]   k_in;
	logic [K_W-1:0]   k_eff;

	// sequencing, digit stack and output register
	state_t                    state_q;
	logic [LEN_W-1:0]          len_q;
	logic [LEN_W-1:0]          cnt_q;
	logic [K_W-1:0]            stk_q [MAX_LEN];
	logic                      out_valid_q;
	logic [SYM_W-1:0]          out_symbol_q;
	logic [ncwg_pkg::POS_W-1:0] char_position_q;
	logic                      last_char_q;
	logic                      too_long_q;

	ncwg_pkg::search_res_t s_res;
	ncwg_pkg::div_res_t    d_res;
	logic [LEN_W-1:0]      s_len;
	logic                  search_start;
	logic                  div_start;
	logic [N_W-1:0]        div_dividend;
	logic                  last_cnt;
	logic                  load_ok;
	logic [REG_SEL_W-1:0]  sym_reg;
	logic [BYTE_W-1:0]     sym_byte;
	logic [SYM_W-1:0]      top_symbol;

	// Saturate the symbol count once, at the write.
	assign k_in  = cfg_data[K_W-1:0];
	assign k_eff = (k_in == '0) ? K_W'(1) : ((k_in > K_SAT) ? K_SAT : k_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_W'(1);
			for (int i = 0; i < ncwg_pkg::NUM_SYM_REGS; i++) begin
				sym_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == ncwg_pkg::CFG_SYMBOL_COUNT) begin
				k_q <= k_eff;
			end else begin
				sym_q[ncwg_pkg::CFG_IDX_W'(cfg_index - ncwg_pkg::CFG_SYMBOLS_BASE)] <= cfg_data;
			end
		end
	end

	ncwg_len_search #(
		.MAX_LEN (MAX_LEN)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (search_start),
		.n      (word_index),
		.k      (k_q),
		.res    (s_res),
		.len    (s_len)
	);

	ncwg_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (k_q),
		.res      (d_res)
	);

	assign in_ready     = (state_q == T_IDLE);
	assign search_start = in_valid && in_ready && (word_index != '0);
	assign load_ok      = !out_valid_q || out_ready;
	// cnt_q counts digits while dividing, then positions while emitting
	assign last_cnt     = (LEN_W'(cnt_q + LEN_W'(1)) == len_q);

	// First division takes the remainder from the search, the rest take the last quotient.
	assign div_start    = ((state_q == T_SEARCH) && s_res.done && !s_res.too_long) ||
	                      ((state_q == T_DIV) && d_res.done && !last_cnt);
	assign div_dividend = (state_q == T_SEARCH) ? s_res.rem : d_res.quot;

	// Map the digit on top of the stack through the symbol table.
	assign sym_reg  = stk_q[0][K_W-1:BYTE_W];
	assign sym_byte = stk_q[0][BYTE_W-1:0];
	always_comb begin
		top_symbol = '0;
		if (sym_reg < REG_SEL_W'(ncwg_pkg::NUM_SYM_REGS)) begin
			top_symbol = sym_q[ncwg_pkg::CFG_IDX_W'(sym_reg)][{sym_byte, 3'b000} +: SYM_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= T_IDLE;
			len_q           <= '0;
			cnt_q           <= '0;
			out_valid_q     <= 1'b0;
			out_symbol_q    <= '0;
			char_position_q <= '0;
			last_char_q     <= 1'b0;
			too_long_q      <= 1'b0;
			for (int i = 0; i < MAX_LEN; i++) begin
				stk_q[i] <= '0;
			end
		end else begin
			// drop the output item once taken; a load below overrides this
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (search_start) begin
						state_q <= T_SEARCH;
					end
				end
				T_SEARCH: begin
					if (s_res.done) begin
						if (s_res.too_long) begin
							state_q <= T_FLAG;
						end else begin
							len_q   <= s_len;
							cnt_q   <= '0;
							state_q <= T_DIV;
						end
					end
				end
				T_DIV: begin
					// digits come least significant first: push so the leading one ends on top
					if (d_res.done) begin
						for (int i = 0; i < MAX_LEN; i++) begin
							if (i == 0) begin
								stk_q[i] <= d_res.digit;
							end else begin
								stk_q[i] <= stk_q[i-1];
							end
						end
						if (last_cnt) begin
							cnt_q   <= '0;
							state_q <= T_EMIT;
						end else begin
							cnt_q <= cnt_q + LEN_W'(1);
						end
					end
				end
				T_FLAG: begin
					if (load_ok) begin
						out_valid_q     <= 1'b1;
						out_symbol_q    <= '0;
						char_position_q <= '0;
						last_char_q     <= 1'b1;
						too_long_q      <= 1'b1;
						state_q         <= T_IDLE;
					end
				end
				T_EMIT: begin
					if (load_ok) begin
						out_valid_q     <= 1'b1;
						out_symbol_q    <= top_symbol;
						char_position_q <= ncwg_pkg::POS_W'(cnt_q);
						last_char_q     <= last_cnt;
						too_long_q      <= 1'b0;
						for (int i = 0; i < MAX_LEN; i++) begin
							if (i == MAX_LEN - 1) begin
								stk_q[i] <= '0;
							end else begin
								stk_q[i] <= stk_q[i+1];
							end
						end
						cnt_q <= cnt_q + LEN_W'(1);
						if (last_cnt) begin
							state_q <= T_IDLE;
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_symbol    = out_symbol_q;
	assign char_position = char_position_q;
	assign last_char     = last_char_q;
	assign too_long      = too_long_q;

endmodule

// File: hdl/ncwg_checker.sv
// Port-level checks of the shortlex word generator, bound to the top level.
module ncwg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [ncwg_pkg::N_W-1:0]        word_index,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ncwg_pkg::SYM_W-1:0]      out_symbol,
	input logic [ncwg_pkg::POS_W-1:0]      char_position,
	input logic                            last_char,
	input logic                            too_long
);

	// a flagged item stands alone
	a_too_long_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> last_char && (out_symbol == '0) && (char_position == '0))
		else $error("too_long item is not a lone zero item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
			$stable(char_position) && $stable(last_char) && $stable(too_long))
		else $error("stalled output item changed");

	// a nonzero index keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (word_index != '0) |=> !in_ready)
		else $error("input accepted again right after a nonzero index");

	// the rest of a word is still to come while a middle character waits
	a_no_accept_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> !in_ready)
		else $error("input ready while a word is still being emitted");

endmodule

bind nth_candidate_word_generator ncwg_checker u_ncwg_checker (.*);
